@@ rtl/core/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue core and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int FILL_W  = 5;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_REMOVED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } spq_status_t;

  // one stored entry of the row
  typedef struct packed {
    logic                      valid;
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
  } spq_entry_t;

  // operation broadcast to every cell, already gated by full and empty
  typedef struct packed {
    logic                      enq;
    logic                      deq;
    logic signed [PRIO_W-1:0]  prio;
    logic signed [VALUE_W-1:0] value;
  } spq_op_t;

endpackage

@@ rtl/core/sorted_priority_queue_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept sorted in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The core takes one word per clock cycle and returns exactly one result word
// for each, registered, in the cycle after acceptance. Every cell compares its
// priority with the incoming one in parallel, so an insert or a removal takes no
// longer for a larger QUEUE_DEPTH; input is held off only
// while a result waits on the output side. Entries of equal priority leave in
// arrival order. A dequeue on an empty queue reports empty, an enqueue on a
// full queue is dropped and reports full. fill_level carries the low five bits
// of the entry count.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // item_value[31:0], item_priority[47:32]
  input  logic        s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_value[31:0], out_priority[47:32],
                                      // fill_level[52:48], zero[55:53]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  spq_entry_t              cell_ent  [QUEUE_DEPTH];
  logic                    cell_keep [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]  valid_vec;
  spq_op_t                 op;

  logic                    in_acc;
  logic                    is_enq;
  logic                    is_deq;
  logic                    full;
  logic                    empty;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [CNT_W+FILL_W-1:0] count_ext;

  spq_status_t             res_status;
  spq_status_t             res_status_next;
  logic [VALUE_W-1:0]      res_value;
  logic [PRIO_W-1:0]       res_prio;
  logic [FILL_W-1:0]       res_fill;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_enq        = s_axis_tuser == ACT_ENQ;
  assign is_deq        = s_axis_tuser == ACT_DEQ;
  assign full          = cell_ent[QUEUE_DEPTH-1].valid;
  assign empty         = !cell_ent[0].valid;

  assign op.enq   = in_acc && is_enq && !full;
  assign op.deq   = in_acc && is_deq && !empty;
  assign op.value = s_axis_tdata[VALUE_W-1:0];
  assign op.prio  = s_axis_tdata[VALUE_W+PRIO_W-1:VALUE_W];

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      spq_entry_t left_ent;
      spq_entry_t right_ent;
      logic       left_keep;

      if (gi == 0) begin : g_head
        assign left_ent  = cell_ent[0];
        assign left_keep = 1'b1;
      end else begin : g_body
        assign left_ent  = cell_ent[gi-1];
        assign left_keep = cell_keep[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_tail
        assign right_ent = '0;
      end else begin : g_inner
        assign right_ent = cell_ent[gi+1];
      end

      spq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .op        (op),
        .left      (left_ent),
        .left_keep (left_keep),
        .right     (right_ent),
        .ent       (cell_ent[gi]),
        .keep      (cell_keep[gi])
      );

      assign valid_vec[gi] = cell_ent[gi].valid;
    end
  endgenerate

  always_comb begin
    count_next      = count;
    res_status_next = ST_ADDED;
    if (is_enq) begin
      if (full) begin
        res_status_next = ST_FULL;
      end else begin
        res_status_next = ST_ADDED;
        count_next      = count + 1'b1;
      end
    end else begin
      if (empty) begin
        res_status_next = ST_EMPTY;
      end else begin
        res_status_next = ST_REMOVED;
        count_next      = count - 1'b1;
      end
    end
  end

  assign count_ext = {{FILL_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_acc) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_status <= res_status_next;
      res_fill   <= count_ext[FILL_W-1:0];
      if (res_status_next == ST_REMOVED) begin
        res_value <= cell_ent[0].value;
        res_prio  <= cell_ent[0].prio;
      end else begin
        res_value <= '0;
        res_prio  <= '0;
      end
    end
  end

  assign m_axis_tuser = res_status;
  assign m_axis_tdata = {3'b000, res_fill, res_prio, res_value};

  // occupied cells always form a prefix of the row
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("entry count disagrees with occupied cells");

  a_result: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  a_full: assert property (@(posedge clk) disable iff (rst)
    in_acc && is_enq && (count == CNT_W'(QUEUE_DEPTH)) |=> res_status == ST_FULL)
    else $error("enqueue on full queue not flagged");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    cell_ent[1].valid |-> ($signed(cell_ent[0].prio) >= $signed(cell_ent[1].prio)))
    else $error("head entry out of priority order");

endmodule

@@ rtl/core/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry, keeps it, takes the new entry,
// or takes a neighbor's entry on insert and removal.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  spq_op_t    op,
  input  spq_entry_t left,
  input  logic       left_keep,
  input  spq_entry_t right,
  output spq_entry_t ent,
  output logic       keep
);

  spq_entry_t entry;
  spq_entry_t entry_next;

  // entry stays ahead of the new one when its priority is greater or equal
  assign keep = entry.valid && ($signed(entry.prio) >= $signed(op.prio));
  assign ent  = entry;

  always_comb begin
    entry_next = entry;
    if (op.enq) begin
      if (keep) begin
        entry_next = entry;
      end else if (left_keep) begin
        entry_next.valid = 1'b1;
        entry_next.prio  = op.prio;
        entry_next.value = op.value;
      end else begin
        entry_next = left;
      end
    end else if (op.deq) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    entry.prio  <= entry_next.prio;
    entry.value <= entry_next.value;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule
